// File: rtl/fpcm_pkg.sv
`default_nettype none
package fpcm_pkg;
	localparam int unsigned FloatW = 32;
	localparam int unsigned PcmW   = 24;
	localparam logic [7:0]  ExpMax = 8'hff;

	localparam logic [0:0] RegSampleBytes = 1'b0;

	typedef struct packed {
		logic [PcmW-1:0] pcm;
		logic [1:0]      nb;
		logic            block_end;
	} conv_t;
endpackage
`default_nettype wire

// File: rtl/fpcm_conv.sv
`default_nettype none
module fpcm_conv (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire logic                        in_valid,
	input  wire logic [fpcm_pkg::FloatW-1:0] float_bits,
	input  wire logic                        block_end,
	input  wire logic [1:0]                  nb,
	output logic                             out_valid,
	output fpcm_pkg::conv_t                  out_item
);
	// s1: unpack and shift amount
	logic        v_s1, neg_s1, nan_s1, big_s1, right_s1, be_s1;
	logic [23:0] m_s1;
	logic [4:0]  sh_s1;
	logic [1:0]  nb_s1;
	// s2: magnitude
	logic        v_s2, neg_s2, nan_s2, be_s2;
	logic [24:0] mag_s2;
	logic [1:0]  nb_s2;
	// s3: clamped signed result
	logic        v_s3;
	fpcm_pkg::conv_t item_s3;

	logic [7:0]  ex;
	logic [22:0] man;
	logic [1:0]  nbe;
	logic [5:0]  nbits;
	logic signed [9:0] k;
	assign ex    = float_bits[30:23];
	assign man   = float_bits[22:0];
	assign nbe   = (nb == 2'd0) ? 2'd1 : nb;
	assign nbits = {1'b0, nbe, 3'b000};
	assign k     = $signed({2'b00, (ex == 8'd0) ? 8'd1 : ex}) - 10'sd151
		+ $signed({4'b0000, nbits});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1   <= float_bits[31];
			nan_s1   <= (ex == fpcm_pkg::ExpMax) && (man != 23'd0);
			be_s1    <= block_end;
			nb_s1    <= nbe;
			m_s1     <= {(ex != 8'd0), man};
			// k never exceeds 24-1 for finite input below 2^1 range, clamp covers rest
			big_s1   <= (ex == fpcm_pkg::ExpMax) || (k > 10'sd1);
			right_s1 <= k < 10'sd0;
			sh_s1    <= (k < -10'sd24) ? 5'd25 : (k < 10'sd0) ? 5'(-k) : 5'(k);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2 <= neg_s1;
			nan_s2 <= nan_s1;
			be_s2  <= be_s1;
			nb_s2  <= nb_s1;
			if (big_s1)
				mag_s2 <= 25'h1000000;
			else if (right_s1)
				mag_s2 <= (sh_s1 > 5'd24) ? 25'd0 : ({1'b0, m_s1} >> sh_s1);
			else
				mag_s2 <= {1'b0, m_s1} << sh_s1[0];
		end
	end

	logic [24:0] top, lim;
	logic [23:0] res;
	always_comb begin
		top = 25'd1 << ({1'b0, nb_s2, 3'b000} - 6'd1);
		lim = neg_s2 ? top : top - 25'd1;
		res = (mag_s2 > lim) ? lim[23:0] : mag_s2[23:0];
		if (neg_s2)
			res = 24'd0 - res;
		if (nan_s2)
			res = 24'd0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s3.pcm       <= res;
			item_s3.nb        <= nb_s2;
			item_s3.block_end <= be_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;
endmodule
`default_nettype wire

// File: rtl/float_to_pcm_clamp_converter.sv
`default_nettype none
// channel | direction | handshake      | payload
// input   | in        | valid / stall  | float_bits, block_end
// output  | out       | ovalid / ostall| pcm_byte, last_byte, block_done
// config  | in        | apb            | sample_bytes at 0x0
// three pipeline stages convert a sample; a byte serialiser then sends
// 1 to 3 bytes, one per cycle while ostall is low, through the single
// byte output port. arst_n clears valids and sets sample_bytes to 3.
// the pipeline advances only while the serialiser slot is free or
// emptying, so a stall holds every item in place.
module float_to_pcm_clamp_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	output logic             stall,
	input  wire logic [31:0] float_bits,
	input  wire logic        block_end,
	output logic             ovalid,
	input  wire logic        ostall,
	output logic [7:0]       pcm_byte,
	output logic             last_byte,
	output logic             block_done,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [0:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [1:0] sample_bytes_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sample_bytes_q <= 2'd3;
		else if (psel && penable && pwrite && paddr == fpcm_pkg::RegSampleBytes)
			sample_bytes_q <= pwdata[1:0];
	end
	assign prdata = (paddr == fpcm_pkg::RegSampleBytes) ? {30'd0, sample_bytes_q} : 32'd0;

	logic            cv;
	fpcm_pkg::conv_t ci;
	logic            busy_q;
	fpcm_pkg::conv_t item_q;
	logic [1:0]      idx_q;
	logic            fin, adv;

	// last byte leaving frees the slot
	assign fin   = busy_q && !ostall && (idx_q == item_q.nb - 2'd1);
	assign adv   = !busy_q || fin;
	assign stall = !adv;

	fpcm_conv u_conv (
		.clk, .arst_n, .adv, .in_valid(valid), .float_bits, .block_end,
		.nb(sample_bytes_q), .out_valid(cv), .out_item(ci)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (adv) begin
			busy_q <= cv;
			idx_q  <= 2'd0;
		end else if (!ostall) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			item_q <= ci;
	end

	logic [1:0] rem;
	assign rem        = item_q.nb - 2'd1 - idx_q;
	assign ovalid     = busy_q;
	assign pcm_byte   = item_q.pcm[{rem, 3'b000} +: 8];
	assign last_byte  = (rem == 2'd0);
	assign block_done = (rem == 2'd0) && item_q.block_end;
endmodule
`default_nettype wire
